// ===== rtl/core/dcd_pkg.sv =====
// Package for the directed cycle detector: sizes, state encoding.
// No dependencies.
package dcd_pkg;
    localparam int NODES = 256;
    localparam int EDGES = 1024;
    localparam int NW = $clog2(NODES);
    localparam int EW = $clog2(EDGES);
    localparam int CW = $clog2(NODES + 1);

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_START,
        ST_HEAD,
        ST_TOP,
        ST_EDGE,
        ST_CHECK,
        ST_TGT,
        ST_POP,
        ST_RESULT,
        ST_CLEAR
    } state_t;
endpackage

// ===== rtl/core/dcd_ram.sv =====
// Generic single-port-write RAM with registered read.
// No dependencies.
module dcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/core/directed_cycle_detector.sv =====
// Directed cycle detector: edge-list load plus iterative DFS walk.
// A word passes through ST_LOAD (accept) and ST_HEAD (store). After the last word the walk
// scans start nodes, follows edges, pushes and pops nodes, gives the result and runs a
// clearing pass of the head/mark RAMs; tready is low until all is done.
// Reset: async active low; a clearing pass of the head/mark RAMs runs after reset.
// Depends on dcd_pkg and dcd_ram.
module directed_cycle_detector (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // edge_from[7:0], edge_to[15:8]
    input  logic        s_axis_tlast,  // last_edge
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // cyclic[0], overflow[1], zero pad
    input  logic        cfg_we,
    input  logic [8:0]  cfg_wdata
);
    import dcd_pkg::*;

    state_t state_reg, state_next;
    logic [8:0] ncount_reg;
    logic [EW:0] stored_reg, stored_next;
    logic drop_reg, drop_next;
    logic [CW-1:0] sp_reg, sp_next;
    logic [CW-1:0] start_reg, start_next;
    logic [NW-1:0] node_reg, node_next;
    logic [NW-1:0] tgt_reg, tgt_next;
    logic [EW:0] cur_reg, cur_next;
    logic [NW-1:0] clr_reg, clr_next;
    logic cyc_reg, cyc_next;
    logic ovf_reg, ovf_next;
    logic oval_reg, oval_next;

    // head RAM: node -> first edge slot (EDGES = empty)
    logic h_we; logic [NW-1:0] h_wa, h_ra; logic [EW:0] h_wd, h_rd;
    // edge RAM: {next, target}
    logic e_we; logic [EW-1:0] e_ra; logic [EW+NW:0] e_wd, e_rd;
    // marks RAM: {seen, on_path}
    logic m_we; logic [NW-1:0] m_wa, m_ra; logic [1:0] m_wd, m_rd;
    // stack RAM: {node, cursor}
    logic s_we; logic [NW-1:0] s_wa, s_ra; logic [EW+NW:0] s_wd, s_rd;

    dcd_ram #(.WIDTH(EW + 1), .DEPTH(NODES)) u_head (
        .clk(clk), .we(h_we), .waddr(h_wa), .wdata(h_wd), .raddr(h_ra), .rdata(h_rd));
    dcd_ram #(.WIDTH(EW + NW + 1), .DEPTH(EDGES)) u_edge (
        .clk(clk), .we(e_we), .waddr(stored_reg[EW-1:0]), .wdata(e_wd),
        .raddr(e_ra), .rdata(e_rd));
    dcd_ram #(.WIDTH(2), .DEPTH(NODES)) u_mark (
        .clk(clk), .we(m_we), .waddr(m_wa), .wdata(m_wd), .raddr(m_ra), .rdata(m_rd));
    dcd_ram #(.WIDTH(EW + NW + 1), .DEPTH(NODES)) u_stack (
        .clk(clk), .we(s_we), .waddr(s_wa), .wdata(s_wd), .raddr(s_ra), .rdata(s_rd));

    logic [NW-1:0] efrom, eto;
    logic [CW-1:0] limit;
    logic acc;
    assign efrom = s_axis_tdata[7:0];
    assign eto = s_axis_tdata[15:8];
    assign limit = (ncount_reg > 9'(NODES)) ? CW'(NODES) : CW'(ncount_reg);
    assign s_axis_tready = (state_reg == ST_LOAD) && !oval_reg;
    assign acc = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = oval_reg;
    assign m_axis_tdata = {6'd0, ovf_reg, cyc_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            ncount_reg <= 9'd256;
            stored_reg <= '0;
            drop_reg <= 1'b0;
            clr_reg <= '0;
            oval_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                ncount_reg <= cfg_wdata;
            end
            stored_reg <= stored_next;
            drop_reg <= drop_next;
            clr_reg <= clr_next;
            oval_reg <= oval_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sp_reg <= sp_next;
        start_reg <= start_next;
        node_reg <= node_next;
        tgt_reg <= tgt_next;
        cur_reg <= cur_next;
        cyc_reg <= cyc_next;
        ovf_reg <= ovf_next;
    end

    always_comb
    begin
        state_next = state_reg;
        stored_next = stored_reg;
        drop_next = drop_reg;
        sp_next = sp_reg;
        start_next = start_reg;
        node_next = node_reg;
        tgt_next = tgt_reg;
        cur_next = cur_reg;
        clr_next = clr_reg;
        cyc_next = cyc_reg;
        ovf_next = ovf_reg;
        oval_next = oval_reg && !m_axis_tready;
        h_we = 1'b0; h_wa = efrom; h_wd = stored_reg; h_ra = efrom;
        e_we = 1'b0; e_wd = {h_rd, eto}; e_ra = cur_reg[EW-1:0];
        m_we = 1'b0; m_wa = tgt_reg; m_wd = 2'b11; m_ra = tgt_reg;
        s_we = 1'b0; s_wa = sp_reg[NW-1:0]; s_wd = {node_reg, cur_reg};
        s_ra = NW'(sp_reg - CW'(1));
        unique case (state_reg)
            ST_LOAD:
            begin
                // head read of efrom issued this cycle; writes happen in ST_HEAD
                if (acc)
                begin
                    node_next = efrom;
                    tgt_next = eto;
                    cyc_next = s_axis_tlast;
                    state_next = ST_HEAD;
                end
            end
            ST_HEAD:
            begin
                // store one edge, or drop it if the store is full; cyc_reg holds last flag here
                if (stored_reg[EW])
                begin
                    drop_next = 1'b1;
                end
                else
                begin
                    e_we = 1'b1;
                    e_wd = {h_rd, tgt_reg};
                    h_we = 1'b1; h_wa = node_reg; h_wd = stored_reg;
                    stored_next = stored_reg + 1'b1;
                end
                if (cyc_reg)
                begin
                    start_next = '0;
                    sp_next = '0;
                    cyc_next = 1'b0;
                    m_ra = '0;
                    state_next = ST_START;
                end
                else
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_START:
            begin
                // m_rd: marks of start_reg; h_rd unread yet
                if (start_reg >= limit)
                begin
                    state_next = ST_RESULT;
                end
                else if (m_rd[1])
                begin
                    start_next = start_reg + 1'b1;
                    m_ra = NW'(start_reg + 1'b1);
                end
                else
                begin
                    tgt_next = NW'(start_reg);
                    h_ra = NW'(start_reg);
                    state_next = ST_TGT;
                end
            end
            ST_TGT:
            begin
                // push tgt_reg with cursor h_rd
                m_we = 1'b1; m_wa = tgt_reg; m_wd = 2'b11;
                s_we = 1'b1; s_wa = sp_reg[NW-1:0]; s_wd = {tgt_reg, h_rd};
                node_next = tgt_reg;
                cur_next = h_rd;
                sp_next = sp_reg + 1'b1;
                e_ra = h_rd[EW-1:0];
                state_next = ST_EDGE;
            end
            ST_TOP:
            begin
                // s_rd holds top entry
                node_next = s_rd[EW+NW:EW+1];
                cur_next = s_rd[EW:0];
                e_ra = s_rd[EW-1:0];
                state_next = ST_EDGE;
            end
            ST_EDGE:
            begin
                // e_rd valid for cur_reg if in range
                if (cur_reg >= stored_reg)
                begin
                    m_we = 1'b1; m_wa = node_reg; m_wd = 2'b10;
                    state_next = ST_POP;
                end
                else
                begin
                    s_we = 1'b1; s_wa = NW'(sp_reg - CW'(1));
                    s_wd = {node_reg, e_rd[EW+NW:NW]};
                    cur_next = e_rd[EW+NW:NW];
                    tgt_next = e_rd[NW-1:0];
                    m_ra = e_rd[NW-1:0];
                    h_ra = e_rd[NW-1:0];
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                // m_rd: marks of tgt_reg; cur_reg already advanced
                if (m_rd[0])
                begin
                    cyc_next = 1'b1;
                    state_next = ST_RESULT;
                end
                else if (!m_rd[1])
                begin
                    h_ra = tgt_reg;
                    state_next = ST_TGT;
                end
                else
                begin
                    state_next = ST_EDGE;
                end
            end
            ST_POP:
            begin
                sp_next = sp_reg - 1'b1;
                if (sp_reg == CW'(1))
                begin
                    start_next = start_reg + 1'b1;
                    m_ra = NW'(start_reg + 1'b1);
                    state_next = ST_START;
                end
                else
                begin
                    s_ra = NW'(sp_reg - CW'(2));
                    state_next = ST_TOP;
                end
            end
            ST_RESULT:
            begin
                if (!oval_reg)
                begin
                    oval_next = 1'b1;
                    ovf_next = drop_reg;
                    clr_next = '0;
                    state_next = ST_CLEAR;
                end
            end
            ST_CLEAR:
            begin
                h_we = 1'b1; h_wa = clr_reg; h_wd = (EW + 1)'(EDGES);
                m_we = 1'b1; m_wa = clr_reg; m_wd = 2'b00;
                stored_next = '0;
                drop_next = 1'b0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == NW'(NODES - 1))
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end
endmodule

// ===== tb/tb.sv =====
// Testbench for directed_cycle_detector: streams directed edges, checks the cyclic and overflow
// flags of each graph against given values or a DFS predictor. Depends on dcd_pkg and the RTL.
`timescale 1ns / 100ps

module tb;
    import dcd_pkg::*;

    typedef struct packed {
        logic [7:0] src;
        logic [7:0] dst;
        logic       last;
    } edge_word_t;

    typedef struct packed {
        logic cyclic;
        logic overflow;
    } verdict_t;

    typedef struct {
        logic [7:0] src;
        logic [7:0] dst;
        logic       last;
        logic       chk;
        logic       cyc;
        logic       ovf;
    } vec_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic        cfg_we = 1'b0;
    logic [8:0]  cfg_wdata = '0;

    int          errors = 0;
    verdict_t    verdict_q[$];
    logic [7:0]  edge_src[$];
    logic [7:0]  edge_dst[$];
    int          node_limit = 256;

    always #5 clk = ~clk;

    directed_cycle_detector i_dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    function automatic verdict_t predict_graph();
        verdict_t   v;
        int         head[NODES];
        int         nxt[EDGES];
        logic [7:0] tgt[EDGES];
        bit         seen[NODES];
        bit         onp[NODES];
        int         stn[NODES];
        int         stc[NODES];
        int         cnt;
        int         sp;
        int         n;
        int         e;
        int         t;
        int         lim;
        v = '0;
        cnt = 0;
        for (int i = 0; i < NODES; i++)
        begin
            head[i] = EDGES;
            seen[i] = 0;
            onp[i] = 0;
        end
        foreach (edge_src[k])
        begin
            if (cnt >= EDGES)
                v.overflow = 1'b1;
            else
            begin
                tgt[cnt] = edge_dst[k];
                nxt[cnt] = head[edge_src[k]];
                head[edge_src[k]] = cnt;
                cnt++;
            end
        end
        lim = (node_limit > NODES) ? NODES : node_limit;
        for (int s = 0; s < lim && !v.cyclic; s++)
        begin
            if (seen[s])
                continue;
            seen[s] = 1;
            onp[s] = 1;
            stn[0] = s;
            stc[0] = head[s];
            sp = 1;
            while (sp > 0 && !v.cyclic)
            begin
                n = stn[sp-1];
                e = stc[sp-1];
                if (e >= cnt)
                begin
                    onp[n] = 0;
                    sp--;
                end
                else
                begin
                    stc[sp-1] = nxt[e];
                    t = tgt[e];
                    if (onp[t])
                        v.cyclic = 1'b1;
                    else if (!seen[t])
                    begin
                        seen[t] = 1;
                        onp[t] = 1;
                        stn[sp] = t;
                        stc[sp] = head[t];
                        sp++;
                    end
                end
            end
        end
        return v;
    endfunction

    task automatic send_word(input edge_word_t w, input logic chk,
                             input logic cyc, input logic ovf);
        verdict_t v;
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(2, 7)) @(posedge clk);
        else
            @(posedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {w.dst, w.src};
        s_axis_tlast <= w.last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        edge_src = {edge_src, w.src};
        edge_dst = {edge_dst, w.dst};
        if (w.last)
        begin
            if (chk)
            begin
                v.cyclic = cyc;
                v.overflow = ovf;
            end
            else
                v = predict_graph();
            verdict_q = {verdict_q, v};
            edge_src.delete();
            edge_dst.delete();
        end
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic set_node_count(input int val);
        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (3000) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= val[8:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        node_limit = val;
    endtask

    task automatic send_graph(input int n_edges, input int span);
        edge_word_t w;
        for (int i = 0; i < n_edges; i++)
        begin
            w.src = 8'($urandom_range(0, span));
            w.dst = 8'($urandom_range(0, span));
            if ($urandom_range(0, 2) == 0 && span > 1)
            begin
                w.dst = w.src + 8'd1 + 8'($urandom_range(0, 3));
            end
            w.last = (i == n_edges - 1);
            send_word(w, 1'b0, 1'b0, 1'b0);
        end
    endtask

    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(0, 7) > 2);
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (verdict_q.size() == 0)
            begin
                $error("result word with nothing expected");
                errors++;
            end
            else
            begin
                if (m_axis_tdata[0] !== verdict_q[0].cyclic)
                begin
                    $error("cyclic: expected %0b actual %0b",
                           verdict_q[0].cyclic, m_axis_tdata[0]);
                    errors++;
                end
                if (m_axis_tdata[1] !== verdict_q[0].overflow)
                begin
                    $error("overflow: expected %0b actual %0b",
                           verdict_q[0].overflow, m_axis_tdata[1]);
                    errors++;
                end
                void'(verdict_q.pop_front());
            end
        end
    end

    initial
    begin
        #200_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        vec_t       dir[$];
        edge_word_t w;
        int         total;
        int         n_edges;
        dir = '{
            '{8'd0,   8'd0,   1'b1, 1'b1, 1'b1, 1'b0},
            '{8'd0,   8'd1,   1'b1, 1'b1, 1'b0, 1'b0},
            '{8'd255, 8'd255, 1'b1, 1'b1, 1'b1, 1'b0},
            '{8'd255, 8'd0,   1'b1, 1'b1, 1'b0, 1'b0},
            '{8'd0,   8'd255, 1'b0, 1'b0, 1'b0, 1'b0},
            '{8'd255, 8'd0,   1'b1, 1'b1, 1'b1, 1'b0},
            '{8'd1,   8'd2,   1'b0, 1'b0, 1'b0, 1'b0},
            '{8'd2,   8'd3,   1'b0, 1'b0, 1'b0, 1'b0},
            '{8'd3,   8'd1,   1'b1, 1'b1, 1'b1, 1'b0},
            '{8'd1,   8'd2,   1'b0, 1'b0, 1'b0, 1'b0},
            '{8'd1,   8'd3,   1'b0, 1'b0, 1'b0, 1'b0},
            '{8'd2,   8'd4,   1'b0, 1'b0, 1'b0, 1'b0},
            '{8'd3,   8'd4,   1'b1, 1'b0, 1'b0, 1'b0},
            '{8'd170, 8'd85,  1'b0, 1'b0, 1'b0, 1'b0},
            '{8'd85,  8'd170, 1'b1, 1'b1, 1'b1, 1'b0}
        };
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        repeat (300) @(posedge clk);
        foreach (dir[i])
        begin
            w.src = dir[i].src;
            w.dst = dir[i].dst;
            w.last = dir[i].last;
            send_word(w, dir[i].chk, dir[i].cyc, dir[i].ovf);
        end
        // store full: 1024 acyclic edges, then more dropped
        for (int i = 0; i < 1026; i++)
        begin
            w.src = 8'(i % 255);
            w.dst = 8'((i % 255) + 1);
            w.last = (i == 1025);
            send_word(w, w.last, 1'b0, 1'b1);
        end
        set_node_count(0);
        w = '{8'd7, 8'd7, 1'b1};
        send_word(w, 1'b1, 1'b0, 1'b0);
        set_node_count(1);
        w = '{8'd1, 8'd1, 1'b1};
        send_word(w, 1'b1, 1'b0, 1'b0);
        w = '{8'd0, 8'd1, 1'b0};
        send_word(w, 1'b0, 1'b0, 1'b0);
        w = '{8'd1, 8'd1, 1'b1};
        send_word(w, 1'b1, 1'b1, 1'b0);
        set_node_count(511);
        total = 0;
        while (total < 100)
        begin
            if ($urandom_range(0, 4) == 0)
                set_node_count($urandom_range(0, 511));
            n_edges = $urandom_range(1, 12);
            send_graph(n_edges, ($urandom_range(0, 3) == 0) ? 255 : $urandom_range(1, 12));
            total += n_edges;
        end
        set_node_count(256);
        send_graph(10, 255);
        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (3000) @(posedge clk);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

// ===== files.f =====
rtl/core/dcd_pkg.sv
rtl/core/dcd_ram.sv
rtl/core/directed_cycle_detector.sv
tb/tb.sv
